/* src/ftqg_pkg.sv */
package ftqg_pkg;

    // Window depth and derived widths
    localparam int WINDOW  = 64;
    localparam int WIN_AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DIV_W   = $clog2(WINDOW + 1);
    localparam int TIME_W  = 24;
    localparam int TOT_W   = TIME_W + WIN_AW;
    localparam int CNT_W   = $clog2(TOT_W + 1);

    localparam int BUDGET_W = 20;
    localparam int RUN_W    = 8;
    localparam int COUNT_W  = 32;
    localparam int GPU_W    = 64;
    localparam int LEVEL_W  = 2;
    localparam int SCALE_W  = 3;
    localparam int CFG_AW   = 3;

    localparam logic [GPU_W-1:0] GPU_MAX_US = GPU_W'(1000000);

    // Quality levels
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd2;
    localparam logic [SCALE_W-1:0] SCALE_FULL = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_BUDGET       = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_LOOSE_BUDGET = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_DEGRADE      = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_RECOVER      = 3'd3;

    // Reset values of the configuration registers
    localparam logic [BUDGET_W-1:0] BUDGET_RST       = 20'd16667;
    localparam logic [BUDGET_W-1:0] LOOSE_BUDGET_RST = 20'd15000;
    localparam logic [RUN_W-1:0]    DEGRADE_RST      = 8'd3;
    localparam logic [RUN_W-1:0]    RECOVER_RST      = 8'd10;

    typedef struct packed {
        logic start;   // read the slot at the write pointer, count the frame
        logic commit;  // retire the oldest time, write the new one
    } t_win_ctl;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] overloads;
    } t_gov_stat;

    typedef struct packed {
        logic [BUDGET_W-1:0] budget;
        logic [BUDGET_W-1:0] loose_budget;
        logic [RUN_W-1:0]    degrade_frames;
        logic [RUN_W-1:0]    recover_frames;
    } t_cfg;

endpackage

/* src/ftqg_window.sv */
module ftqg_window
    import ftqg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_win_ctl            i_ctl,
    input  logic [TIME_W-1:0]   i_time,
    output logic [TOT_W-1:0]    o_total,
    output logic [DIV_W-1:0]    o_divisor,
    output logic [COUNT_W-1:0]  o_frames
);

    logic [TIME_W-1:0]  r_mem [WINDOW];
    logic [TIME_W-1:0]  r_rd_data;
    logic [WIN_AW-1:0]  r_pos;
    logic [TOT_W-1:0]   r_total;
    logic [COUNT_W-1:0] r_frames;
    logic               r_full;

    logic [TIME_W-1:0]  oldest;
    logic [WIN_AW-1:0]  n_pos;
    logic [TOT_W-1:0]   n_total;

    // Slots are filled in order, so a slot is unwritten until a full lap is done
    always_comb begin
        oldest  = r_full ? r_rd_data : '0;
        n_total = r_total - TOT_W'(oldest) + TOT_W'(i_time);
        n_pos   = (r_pos == WIN_AW'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rd_data <= r_mem[r_pos];
        end
        if (i_ctl.commit) begin
            r_mem[r_pos] <= i_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_total  <= '0;
            r_frames <= '0;
            r_full   <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_full <= (r_frames >= COUNT_W'(WINDOW));
                if (r_frames != '1) begin
                    r_frames <= r_frames + 1'b1;
                end
            end
            if (i_ctl.commit) begin
                r_total <= n_total;
                r_pos   <= n_pos;
            end
        end
    end

    assign o_total   = r_total;
    assign o_frames  = r_frames;
    // Divide by the frame count during warm-up, by the window depth after
    assign o_divisor = (r_frames < COUNT_W'(WINDOW)) ? r_frames[DIV_W-1:0]
                                                      : DIV_W'(WINDOW);

endmodule

/* src/ftqg_div.sv */
module ftqg_div
    import ftqg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TOT_W-1:0]   i_num,
    input  logic [DIV_W-1:0]   i_den,
    output logic               o_done,
    output logic [TOT_W-1:0]   o_quot
);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [TOT_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DIV_W:0]   shifted;
    logic             ge;
    logic [DIV_W:0]   diff;

    // One quotient bit per cycle, restoring
    always_comb begin
        shifted = {r_rem, r_quot[TOT_W-1]};
        ge      = (shifted >= {1'b0, r_den});
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_den  <= i_den;
                r_quot <= i_num;
                r_cnt  <= CNT_W'(TOT_W);
            end else if (r_cnt != '0) begin
                r_rem  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
                r_quot <= {r_quot[TOT_W-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* src/ftqg_gov.sv */
module ftqg_gov
    import ftqg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_update,
    input  logic [TIME_W-1:0]   i_time,
    input  t_cfg                i_cfg,
    output t_gov_stat           o_stat
);

    logic [LEVEL_W-1:0] r_level;
    logic [RUN_W-1:0]   r_over_run;
    logic [RUN_W-1:0]   r_good_run;
    logic [COUNT_W-1:0] r_overloads;

    logic [LEVEL_W-1:0] n_level;
    logic [RUN_W-1:0]   n_over_run;
    logic [RUN_W-1:0]   n_good_run;
    logic [COUNT_W-1:0] n_overloads;
    logic               over;
    logic               good;

    always_comb begin
        over        = (i_time > TIME_W'(i_cfg.budget));
        good        = (i_time < TIME_W'(i_cfg.loose_budget));
        n_level     = r_level;
        n_overloads = r_overloads;
        n_over_run  = r_over_run;
        n_good_run  = r_good_run;

        if (over) begin
            if (r_overloads != '1) n_overloads = r_overloads + 1'b1;
            if (r_over_run != '1)  n_over_run  = r_over_run + 1'b1;
            n_good_run = '0;
        end else begin
            n_over_run = '0;
            if (r_level != LEVEL_HIGH && good) begin
                if (r_good_run != '1) n_good_run = r_good_run + 1'b1;
            end else begin
                n_good_run = '0;
            end
        end

        // Degrade first; recovery is checked against the updated level
        if (n_over_run >= i_cfg.degrade_frames && n_level != LEVEL_LOW) begin
            n_level    = n_level + 1'b1;
            n_over_run = '0;
            n_good_run = '0;
        end
        if (n_good_run >= i_cfg.recover_frames && n_level != LEVEL_HIGH) begin
            n_level    = n_level - 1'b1;
            n_good_run = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LEVEL_HIGH;
            r_over_run  <= '0;
            r_good_run  <= '0;
            r_overloads <= '0;
        end else if (i_update) begin
            r_level     <= n_level;
            r_over_run  <= n_over_run;
            r_good_run  <= n_good_run;
            r_overloads <= n_overloads;
        end
    end

    assign o_stat.level     = r_level;
    assign o_stat.overloads = r_overloads;

endmodule

/* src/frame_time_quality_governor_core.sv */
// Each frame passes in order through the accept, the read-modify-write of the
//   window memory, the divider launch, the 30-step iterative divider for the
//   window average, the divider done check and the output load. A new frame
//   is taken only after the last result is loaded; a stall on the result
//   channel holds the output load until the output slot is free.
// Reset (synchronous, active low): quality high, counters and window sum zero,
//   configuration back to its defaults; no memory clearing pass is needed.
module frame_time_quality_governor_core
    import ftqg_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // Frame report channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [GPU_W-1:0]      i_gpu_time_us,
    input  logic [TIME_W-1:0]            i_cpu_time_us,

    // Result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [LEVEL_W-1:0]           o_quality_level,
    output logic                         o_degraded,
    output logic [SCALE_W-1:0]           o_scale_quarters,
    output logic [TIME_W-1:0]            o_rolling_avg_us,
    output logic [TIME_W-1:0]            o_frame_time_us,
    output logic [COUNT_W-1:0]           o_overload_count,
    output logic [COUNT_W-1:0]           o_frame_number,

    // Configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_AW-1:0]            i_cfg_index,
    input  logic [BUDGET_W-1:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,     // wait for a frame beat; window slot read issued on accept
        S_RMW,      // read data back: update sum, write slot, run governor
        S_DSTART,   // launch the average divider on the new sum
        S_DIV,      // divider iterating
        S_DONE      // load the result beat once the output slot is free
    } t_state;

    t_state             r_state;
    t_cfg               r_cfg;
    logic [TIME_W-1:0]  r_time;

    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_quality_level;
    logic [TIME_W-1:0]  r_rolling_avg;
    logic [TIME_W-1:0]  r_frame_time;
    logic [COUNT_W-1:0] r_overload_count;
    logic [COUNT_W-1:0] r_frame_number;

    logic               in_accept;
    logic               gpu_ok;
    logic [TIME_W-1:0]  chosen_time;
    logic               out_free;
    t_win_ctl           win_ctl;
    logic [TOT_W-1:0]   win_total;
    logic [DIV_W-1:0]   win_divisor;
    logic [COUNT_W-1:0] win_frames;
    logic               div_done;
    logic [TOT_W-1:0]   div_quot;
    t_gov_stat          gov_stat;

    // Take one frame at a time; the result register parts us from the sink,
    // so a new frame is taken while the last result still waits.
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    // GPU time counts only in 1..1000000; zero, negative and too large fall
    // back to the CPU time.
    assign gpu_ok      = !i_gpu_time_us[GPU_W-1] && (i_gpu_time_us != '0)
                         && (i_gpu_time_us <= GPU_MAX_US);
    assign chosen_time = gpu_ok ? i_gpu_time_us[TIME_W-1:0] : i_cpu_time_us;

    assign win_ctl.start  = in_accept;
    assign win_ctl.commit = (r_state == S_RMW);

    ftqg_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (win_ctl),
        .i_time    (r_time),
        .o_total   (win_total),
        .o_divisor (win_divisor),
        .o_frames  (win_frames)
    );

    ftqg_gov u_gov (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (r_state == S_RMW),
        .i_time   (r_time),
        .i_cfg    (r_cfg),
        .o_stat   (gov_stat)
    );

    ftqg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_num   (win_total),
        .i_den   (win_divisor),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Configuration registers; writes land only while the block is idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.budget         <= BUDGET_RST;
            r_cfg.loose_budget   <= LOOSE_BUDGET_RST;
            r_cfg.degrade_frames <= DEGRADE_RST;
            r_cfg.recover_frames <= RECOVER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BUDGET:       r_cfg.budget         <= i_cfg_data;
                CFG_LOOSE_BUDGET: r_cfg.loose_budget   <= i_cfg_data;
                CFG_DEGRADE:      r_cfg.degrade_frames <= i_cfg_data[RUN_W-1:0];
                CFG_RECOVER:      r_cfg.recover_frames <= i_cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and result beat registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Drop valid once the beat is taken, unless a new one loads now
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_time  <= chosen_time;
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold the quotient until the output slot drains
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_quality_level  <= gov_stat.level;
                        r_rolling_avg    <= div_quot[TIME_W-1:0];
                        r_frame_time     <= r_time;
                        r_overload_count <= gov_stat.overloads;
                        r_frame_number   <= win_frames;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_quality_level  = r_quality_level;
    assign o_degraded       = (r_quality_level != LEVEL_HIGH);
    assign o_scale_quarters = SCALE_FULL - SCALE_W'(r_quality_level);
    assign o_rolling_avg_us = r_rolling_avg;
    assign o_frame_time_us  = r_frame_time;
    assign o_overload_count = r_overload_count;
    assign o_frame_number   = r_frame_number;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("frame accepted without leaving idle");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_overloads_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_overload_count <= o_frame_number))
        else $error("more overloads than frames");

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |=> (gov_stat.level <= LEVEL_LOW))
        else $error("quality level beyond lowest");
`endif

endmodule

/* test/ftqg_checker.sv */
`timescale 1ns / 1ps

module ftqg_checker
    import ftqg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [GPU_W-1:0]        i_gpu_time_us,
    input  logic [TIME_W-1:0]       i_cpu_time_us,

    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [LEVEL_W-1:0]      i_quality_level,
    input  logic                    i_degraded,
    input  logic [SCALE_W-1:0]      i_scale_quarters,
    input  logic [TIME_W-1:0]       i_rolling_avg_us,
    input  logic [TIME_W-1:0]       i_frame_time_us,
    input  logic [COUNT_W-1:0]      i_overload_count,
    input  logic [COUNT_W-1:0]      i_frame_number,

    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_AW-1:0]       i_cfg_index,
    input  logic [BUDGET_W-1:0]     i_cfg_data,

    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic               degraded;
        logic [SCALE_W-1:0] scale;
        logic [TIME_W-1:0]  avg_us;
        logic [TIME_W-1:0]  frame_us;
        logic [COUNT_W-1:0] overloads;
        logic [COUNT_W-1:0] frame_no;
    } t_gov_result;

    t_cfg               gov_cfg;
    logic [TIME_W-1:0]  frame_hist [WINDOW];
    logic [WIN_AW-1:0]  hist_pos;
    logic [TOT_W-1:0]   hist_sum;
    logic [COUNT_W-1:0] frames_cnt;
    logic [COUNT_W-1:0] overload_cnt;
    logic [RUN_W-1:0]   over_len;
    logic [RUN_W-1:0]   good_len;
    logic [LEVEL_W-1:0] gov_level;
    t_gov_result        expected_results [$];
    int                 fails = 0;

    // Pick the frame time, slide the window, step the quality governor.
    task automatic predict_frame(input logic [GPU_W-1:0] gpu, input logic [TIME_W-1:0] cpu);
        logic [TIME_W-1:0] ft;
        logic [TOT_W-1:0]  avg;
        t_gov_result       r;
        if (frames_cnt != '1) frames_cnt++;
        // unsigned view: negative times land far above the limit
        ft = (gpu >= 1 && gpu <= GPU_MAX_US) ? gpu[TIME_W-1:0] : cpu;
        hist_sum = hist_sum - TOT_W'(frame_hist[hist_pos]) + TOT_W'(ft);
        frame_hist[hist_pos] = ft;
        hist_pos = (hist_pos == WIN_AW'(WINDOW - 1)) ? '0 : hist_pos + 1'b1;
        if (frames_cnt < WINDOW) avg = TOT_W'(hist_sum / frames_cnt);
        else avg = TOT_W'(hist_sum / WINDOW);

        if (ft > TIME_W'(gov_cfg.budget)) begin
            if (overload_cnt != '1) overload_cnt++;
            if (over_len != '1) over_len++;
            good_len = '0;
        end else begin
            over_len = '0;
            if (gov_level != LEVEL_HIGH && ft < TIME_W'(gov_cfg.loose_budget)) begin
                if (good_len != '1) good_len++;
            end else begin
                good_len = '0;
            end
        end
        if (over_len >= gov_cfg.degrade_frames && gov_level != LEVEL_LOW) begin
            gov_level++;
            over_len = '0;
            good_len = '0;
        end
        if (good_len >= gov_cfg.recover_frames && gov_level != LEVEL_HIGH) begin
            gov_level--;
            good_len = '0;
        end

        r.level     = gov_level;
        r.degraded  = (gov_level != LEVEL_HIGH);
        r.scale     = SCALE_FULL - SCALE_W'(gov_level);
        r.avg_us    = avg[TIME_W-1:0];
        r.frame_us  = ft;
        r.overloads = overload_cnt;
        r.frame_no  = frames_cnt;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_gov_result want;
        if (!i_rst_n) begin
            gov_cfg.budget         = BUDGET_RST;
            gov_cfg.loose_budget   = LOOSE_BUDGET_RST;
            gov_cfg.degrade_frames = DEGRADE_RST;
            gov_cfg.recover_frames = RECOVER_RST;
            foreach (frame_hist[i]) frame_hist[i] = '0;
            hist_pos     = '0;
            hist_sum     = '0;
            frames_cnt   = '0;
            overload_cnt = '0;
            over_len     = '0;
            good_len     = '0;
            gov_level    = LEVEL_HIGH;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BUDGET:       gov_cfg.budget         = i_cfg_data;
                    CFG_LOOSE_BUDGET: gov_cfg.loose_budget   = i_cfg_data;
                    CFG_DEGRADE:      gov_cfg.degrade_frames = i_cfg_data[RUN_W-1:0];
                    CFG_RECOVER:      gov_cfg.recover_frames = i_cfg_data[RUN_W-1:0];
                    default: ;
                endcase
            end
            // compare before predicting so a stray beat never meets a fresh entry
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, frame_number %0d",
                             $time, i_frame_number);
                    fails++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    compare_field("quality_level", want.level, i_quality_level);
                    compare_field("degraded", want.degraded, i_degraded);
                    compare_field("scale_quarters", want.scale, i_scale_quarters);
                    compare_field("rolling_avg_us", want.avg_us, i_rolling_avg_us);
                    compare_field("frame_time_us", want.frame_us, i_frame_time_us);
                    compare_field("overload_count", want.overloads, i_overload_count);
                    compare_field("frame_number", want.frame_no, i_frame_number);
                end
            end
            if (i_in_valid && !i_in_stall) predict_frame(i_gpu_time_us, i_cpu_time_us);
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

/* test/tb_frame_time_quality_governor_core.sv */
`timescale 1ns / 1ps

module tb_frame_time_quality_governor_core;
    import ftqg_pkg::*;

    // Quiet cycles allowed before the run is declared hung. One frame's processing
    // plus stall bursts on either side must fit well within it.
    localparam int IDLE_LIMIT   = 2000;
    // Cycles to linger after the last result so stray beats get caught.
    localparam int DRAIN_CYCLES = 40;
    localparam int TIME_MAX     = 2**TIME_W - 1;
    localparam int GPU_LIMIT    = 1000000;

    typedef enum {FRAMES_OVER, FRAMES_GOOD, FRAMES_NEUTRAL, FRAMES_NOISE} t_run_kind;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [GPU_W-1:0]        i_gpu_time_us;
    logic [TIME_W-1:0]       i_cpu_time_us;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [LEVEL_W-1:0]      o_quality_level;
    logic                    o_degraded;
    logic [SCALE_W-1:0]      o_scale_quarters;
    logic [TIME_W-1:0]       o_rolling_avg_us;
    logic [TIME_W-1:0]       o_frame_time_us;
    logic [COUNT_W-1:0]      o_overload_count;
    logic [COUNT_W-1:0]      o_frame_number;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_AW-1:0]       i_cfg_index;
    logic [BUDGET_W-1:0]     i_cfg_data;

    int                      fail_count;
    int                      pending;

    // Stimulus knobs: the live thresholds shape the frame times we generate,
    // idle_on turns random gaps and stalls on or off.
    logic [BUDGET_W-1:0]     cur_budget = BUDGET_RST;
    logic [BUDGET_W-1:0]     cur_loose  = LOOSE_BUDGET_RST;
    bit                      idle_on    = 1'b1;
    int                      stall_left = 0;
    int                      quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    frame_time_quality_governor_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_gpu_time_us    (i_gpu_time_us),
        .i_cpu_time_us    (i_cpu_time_us),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_quality_level  (o_quality_level),
        .o_degraded       (o_degraded),
        .o_scale_quarters (o_scale_quarters),
        .o_rolling_avg_us (o_rolling_avg_us),
        .o_frame_time_us  (o_frame_time_us),
        .o_overload_count (o_overload_count),
        .o_frame_number   (o_frame_number),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    ftqg_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_gpu_time_us    (i_gpu_time_us),
        .i_cpu_time_us    (i_cpu_time_us),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_quality_level  (o_quality_level),
        .i_degraded       (o_degraded),
        .i_scale_quarters (o_scale_quarters),
        .i_rolling_avg_us (o_rolling_avg_us),
        .i_frame_time_us  (o_frame_time_us),
        .i_overload_count (o_overload_count),
        .i_frame_number   (o_frame_number),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Result side back-pressure: bursts of stalled cycles of random length,
    // started at random while idling is on, no new burst once it is off.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left  <= $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: count cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one frame report and hold it until the block takes the beat.
    // Valid stays high on return so back-to-back frames need no gap in valid;
    // while idling is on, a random gap drops it first.
    task automatic send_frame(input logic [GPU_W-1:0] gpu, input logic [TIME_W-1:0] cpu);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_gpu_time_us <= gpu;
        i_cpu_time_us <= cpu;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every expected result has come back. The first
    // edge lets the checker's count catch up with the last accepted beat.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write all four registers back to back, then one write to an unused index
    // that the block must ignore.
    task automatic program_governor(input logic [BUDGET_W-1:0] budget,
                                    input logic [BUDGET_W-1:0] loose,
                                    input logic [RUN_W-1:0] degrade,
                                    input logic [RUN_W-1:0] recover);
        logic [CFG_AW-1:0]   idx  [5];
        logic [BUDGET_W-1:0] data [5];
        idx  = '{CFG_BUDGET, CFG_LOOSE_BUDGET, CFG_DEGRADE, CFG_RECOVER,
                 CFG_AW'($urandom_range(CFG_RECOVER + 1, 2**CFG_AW - 1))};
        data = '{budget, loose, BUDGET_W'(degrade), BUDGET_W'(recover), BUDGET_W'($urandom)};
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= data[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_budget = budget;
        cur_loose  = loose;
    endtask

    // Choose a frame time of the wanted class against the live thresholds.
    function automatic logic [TIME_W-1:0] pick_time(input t_run_kind kind);
        int b;
        int l;
        int lo;
        b = cur_budget;
        l = cur_loose;
        case (kind)
            FRAMES_OVER: begin
                lo = b + 1;
                if ($urandom_range(0, 3) == 0) return TIME_W'($urandom_range(lo, TIME_MAX));
                return TIME_W'($urandom_range(lo, lo + 3000));
            end
            FRAMES_GOOD: begin
                if (l == 0) return '0;
                lo = (l > 3000) ? l - 3000 : 0;
                if ($urandom_range(0, 1) == 0) return TIME_W'($urandom_range(lo, l - 1));
                return TIME_W'($urandom_range(0, l - 1));
            end
            FRAMES_NEUTRAL: begin
                if (l <= b) return TIME_W'($urandom_range(l, b));
                return TIME_W'($urandom_range(0, b));
            end
            default: return TIME_W'($urandom_range(0, TIME_MAX));
        endcase
    endfunction

    // Encode a chosen frame time: either as a valid GPU time with a random CPU
    // fallback, or as the CPU time behind an unusable GPU value.
    task automatic send_time(input logic [TIME_W-1:0] t);
        logic [GPU_W-1:0] gpu;
        if (t >= 1 && t <= GPU_LIMIT && $urandom_range(0, 3) != 0) begin
            send_frame(GPU_W'(t), TIME_W'($urandom));
        end else begin
            case ($urandom_range(0, 4))
                0: gpu = '0;
                1: gpu = {1'b1, 31'($urandom), 32'($urandom)};
                2: gpu = -GPU_W'($urandom_range(1, 1000));
                3: gpu = GPU_W'(GPU_LIMIT + 1 + $urandom_range(0, 1 << 20));
                default: gpu = {2'b01, 30'($urandom), 32'($urandom)};
            endcase
            send_frame(gpu, t);
        end
    endtask

    // Runs of one frame class at a time, so the over and good streaks get long
    // enough to move the quality level; noise frames break the pattern.
    task automatic run_frames(input int n_items, input int max_run, input bit allow_idle);
        int        sent;
        int        run_len;
        int        r;
        t_run_kind kind;
        sent = 0;
        while (sent < n_items) begin
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            kind = (r < 35) ? FRAMES_OVER : (r < 70) ? FRAMES_GOOD :
                   (r < 85) ? FRAMES_NEUTRAL : FRAMES_NOISE;
            run_len = $urandom_range(1, max_run);
            repeat (run_len) send_time(pick_time(kind));
            sent += run_len;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_gpu_time_us <= '0;
        i_cpu_time_us <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_BUDGET;
        i_cfg_data    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds: fallback cases, field extremes and budget edges.
        send_frame('0, '0);                                       // zero GPU, zero time
        send_frame('1, TIME_W'(TIME_MAX));                        // GPU -1, largest CPU
        send_frame({1'b1, 63'd0}, 24'd16668);                     // most negative, budget+1
        send_frame({1'b0, {63{1'b1}}}, 24'd20000);                // most positive, degrade
        send_frame(GPU_MAX_US, 24'h555555);                       // top valid GPU time
        send_frame(GPU_MAX_US + 1, 24'd16667);                    // just past it, at budget
        send_frame(GPU_W'(1), 24'hAAAAAA);                        // smallest GPU, good frame
        send_frame(GPU_W'(15000), '0);                            // at loose budget
        send_frame(GPU_W'(14999), '0);                            // just under loose budget
        drain();

        // Short runs: climb to low quality, saturate there, come back down.
        program_governor(20'd1000, 20'd500, 8'd2, 8'd2);
        repeat (6) send_frame(GPU_W'(1001), 24'd3);
        repeat (2) send_frame(GPU_W'(499), 24'd7);
        send_frame(GPU_W'(500), 24'd9);
        repeat (2) send_frame('0, 24'd499);
        send_frame(GPU_W'(1), 24'd0);
        drain();

        program_governor(BUDGET_RST, LOOSE_BUDGET_RST, DEGRADE_RST, RECOVER_RST);
        run_frames(150, 13, 1'b1);
        drain();

        // Lowest thresholds: every nonzero frame is over budget, none is good.
        program_governor('0, '0, 8'd1, 8'd1);
        run_frames(100, 4, 1'b1);
        drain();

        // Highest thresholds and longest streaks.
        program_governor(BUDGET_W'(GPU_LIMIT), BUDGET_W'(GPU_LIMIT), 8'd255, 8'd255);
        run_frames(400, 300, 1'b1);
        drain();

        repeat (3) begin
            program_governor(BUDGET_W'($urandom_range(1, GPU_LIMIT)),
                             BUDGET_W'($urandom_range(0, GPU_LIMIT)),
                             RUN_W'($urandom_range(1, 6)), RUN_W'($urandom_range(1, 12)));
            run_frames(130, 15, 1'b1);
            drain();
        end

        // Zero streak registers: every frame degrades unless already lowest, then recovers.
        program_governor(BUDGET_W'($urandom_range(0, 40000)),
                         BUDGET_W'($urandom_range(0, 40000)), '0, '0);
        run_frames(100, 4, 1'b1);
        drain();

        // Last stretch at full rate, no gaps and no stalls.
        program_governor(BUDGET_RST, LOOSE_BUDGET_RST, DEGRADE_RST, RECOVER_RST);
        run_frames(100, 13, 1'b0);
        idle_on = 1'b0;
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
src/ftqg_pkg.sv
src/ftqg_window.sv
src/ftqg_div.sv
src/ftqg_gov.sv
src/frame_time_quality_governor_core.sv
test/ftqg_checker.sv
test/tb_frame_time_quality_governor_core.sv
